// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the node table.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define NTL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check on every clock edge, reset included.
`define NTL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- src/ntl_pkg.sv -----
// ----------------------------------------------------------------------------
// ntl_pkg
// Types and constants shared by the node table modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ntl_pkg;

  localparam int KEY_W   = 32;
  localparam int TIME_W  = 32;
  localparam int SLOT_W  = 5;
  localparam int COUNT_W = 6;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_UPSERT = 1'b1
  } op_t;

  typedef struct packed {
    logic              operation;
    logic [KEY_W-1:0]  node_id;
    logic [TIME_W-1:0] timestamp;
  } request_t;

  typedef struct packed {
    logic               hit;
    logic [SLOT_W-1:0]  slot;
    logic               inserted;
    logic               evicted;
    logic [COUNT_W-1:0] entry_count;
  } result_t;

  // Control flags that ride along with a search transaction.
  typedef struct packed {
    logic live;
    logic found;
    logic best_set;
  } cell_flags_t;

endpackage

// ----- src/ntl_cell.sv -----
// ----------------------------------------------------------------------------
// ntl_cell
// One table entry plus one stage of the search chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ntl_cell #(
  parameter int IDX_W       = 5,
  parameter int CELL_INDEX  = 0
) (
  input  logic                        clk,
  input  logic                        rst,
  input  ntl_pkg::cell_flags_t        in_flags,
  input  logic [ntl_pkg::KEY_W-1:0]   in_key,
  input  logic [IDX_W-1:0]            in_found_idx,
  input  logic [ntl_pkg::TIME_W-1:0]  in_best_time,
  input  logic [IDX_W-1:0]            in_best_idx,
  output ntl_pkg::cell_flags_t        out_flags,
  output logic [ntl_pkg::KEY_W-1:0]   out_key,
  output logic [IDX_W-1:0]            out_found_idx,
  output logic [ntl_pkg::TIME_W-1:0]  out_best_time,
  output logic [IDX_W-1:0]            out_best_idx,
  input  logic                        wr_en,
  input  logic [IDX_W-1:0]            wr_idx,
  input  logic [ntl_pkg::KEY_W-1:0]   wr_key,
  input  logic [ntl_pkg::TIME_W-1:0]  wr_time
);
  import ntl_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

  logic              entry_valid;
  logic [KEY_W-1:0]  entry_key;
  logic [TIME_W-1:0] entry_time;

  cell_flags_t       flags_next;
  logic [IDX_W-1:0]  found_idx_next;
  logic [TIME_W-1:0] best_time_next;
  logic [IDX_W-1:0]  best_idx_next;
  logic              key_match;
  logic              older;

  assign key_match = entry_valid && (entry_key == in_key);
  assign older     = entry_valid && (!in_flags.best_set || (entry_time < in_best_time));

  always_comb begin
    flags_next     = in_flags;
    found_idx_next = in_found_idx;
    best_time_next = in_best_time;
    best_idx_next  = in_best_idx;
    if (key_match && !in_flags.found) begin
      flags_next.found = 1'b1;
      found_idx_next   = MY_IDX;
    end
    if (older) begin
      flags_next.best_set = 1'b1;
      best_time_next      = entry_time;
      best_idx_next       = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_flags   <= '0;
      entry_valid <= 1'b0;
    end else begin
      out_flags <= flags_next;
      if (wr_en && (wr_idx == MY_IDX)) begin
        entry_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_key       <= in_key;
    out_found_idx <= found_idx_next;
    out_best_time <= best_time_next;
    out_best_idx  <= best_idx_next;
    if (wr_en && (wr_idx == MY_IDX)) begin
      entry_key  <= wr_key;
      entry_time <= wr_time;
    end
  end

endmodule

// ----- src/ntl_ctrl.sv -----
// ----------------------------------------------------------------------------
// ntl_ctrl
// Transaction sequencer: launches the search, decides and writes back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module ntl_ctrl #(
  parameter int TABLE_DEPTH = 32,
  parameter int IDX_W       = 5,
  parameter int CNT_W       = 6
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  ntl_pkg::request_t           request,
  output logic                        done,
  output ntl_pkg::result_t            result,
  output ntl_pkg::cell_flags_t        head_flags,
  output logic [ntl_pkg::KEY_W-1:0]   head_key,
  input  ntl_pkg::cell_flags_t        tail_flags,
  input  logic [ntl_pkg::KEY_W-1:0]   tail_key,
  input  logic [IDX_W-1:0]            tail_found_idx,
  input  logic [IDX_W-1:0]            tail_best_idx,
  output logic                        wr_en,
  output logic [IDX_W-1:0]            wr_idx,
  output logic [ntl_pkg::KEY_W-1:0]   wr_key,
  output logic [ntl_pkg::TIME_W-1:0]  wr_time
);
  import ntl_pkg::*;

  localparam logic [CNT_W-1:0] FULL = CNT_W'(TABLE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_WRITE  = 3'b100
  } state_t;

  state_t            state;
  state_t            state_next;
  logic              operation;
  logic [TIME_W-1:0] timestamp;
  logic [CNT_W-1:0]  count;
  logic              accept;
  logic              finish;
  result_t           result_next;
  logic [IDX_W-1:0]  wr_idx_next;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign finish = (state == S_SEARCH) && tail_flags.live;

  always_comb begin
    head_flags          = '0;
    head_flags.live     = accept;
    head_key            = request.node_id;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (accept) state_next = S_SEARCH;
      S_SEARCH: if (tail_flags.live) state_next = S_WRITE;
      S_WRITE:  state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    result_next             = '0;
    result_next.hit         = tail_flags.found;
    result_next.entry_count = COUNT_W'(count);
    wr_idx_next             = tail_found_idx;
    if (tail_flags.found) begin
      result_next.slot = SLOT_W'(tail_found_idx);
    end else if (operation == OP_UPSERT) begin
      result_next.inserted = 1'b1;
      if (count < FULL) begin
        result_next.slot        = SLOT_W'(count);
        result_next.entry_count = COUNT_W'(count + 1'b1);
        wr_idx_next             = IDX_W'(count);
      end else begin
        result_next.slot    = SLOT_W'(tail_best_idx);
        result_next.evicted = 1'b1;
        wr_idx_next         = tail_best_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
      wr_en <= 1'b0;
    end else begin
      state <= state_next;
      done  <= finish;
      wr_en <= finish && (operation == OP_UPSERT);
      if (finish && (operation == OP_UPSERT) && !tail_flags.found && (count < FULL)) begin
        count <= count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      operation <= request.operation;
      timestamp <= request.timestamp;
    end
    if (finish) begin
      wr_key  <= tail_key;
      wr_time <= timestamp;
      result  <= result_next;
      wr_idx  <= wr_idx_next;
    end
  end

  `NTL_ASSERT(a_count_range, count <= FULL, "entry count above table depth")
  `NTL_ASSERT(a_done_in_write, done |-> (state == S_WRITE), "result outside write-back")
  `NTL_ASSERT(a_evict_full, (done && result.evicted) |-> (count == FULL), "eviction with free slot")
  `NTL_ASSERT(a_tail_only_searching, tail_flags.live |-> (state == S_SEARCH), "stray transaction")

endmodule

// ----- src/node_table_upsert_lru_evict.sv -----
// ----------------------------------------------------------------------------
// node_table_upsert_lru_evict
// Associative node table with lookup, upsert and least-recently-heard eviction.
// ----------------------------------------------------------------------------
// Each transaction runs from the accepting edge through the search, in which
// the request passes one cell of the entry chain per cycle, then through the
// write-back state; busy stays high for that whole span. The result is shown
// for exactly one cycle with done high and is never held, so the receiver must
// take it on that cycle. After reset the table is empty and ready at once.
`timescale 1ns / 1ps

module node_table_upsert_lru_evict #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  ntl_pkg::request_t request,
  output logic              done,
  output ntl_pkg::result_t  result
);
  import ntl_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  cell_flags_t       chain_flags     [TABLE_DEPTH+1];
  logic [KEY_W-1:0]  chain_key       [TABLE_DEPTH+1];
  logic [IDX_W-1:0]  chain_found_idx [TABLE_DEPTH+1];
  logic [TIME_W-1:0] chain_best_time [TABLE_DEPTH+1];
  logic [IDX_W-1:0]  chain_best_idx  [TABLE_DEPTH+1];

  logic              wr_en;
  logic [IDX_W-1:0]  wr_idx;
  logic [KEY_W-1:0]  wr_key;
  logic [TIME_W-1:0] wr_time;

  assign chain_found_idx[0] = '0;
  assign chain_best_time[0] = '0;
  assign chain_best_idx[0]  = '0;

  ntl_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .request        (request),
    .done           (done),
    .result         (result),
    .head_flags     (chain_flags[0]),
    .head_key       (chain_key[0]),
    .tail_flags     (chain_flags[TABLE_DEPTH]),
    .tail_key       (chain_key[TABLE_DEPTH]),
    .tail_found_idx (chain_found_idx[TABLE_DEPTH]),
    .tail_best_idx  (chain_best_idx[TABLE_DEPTH]),
    .wr_en          (wr_en),
    .wr_idx         (wr_idx),
    .wr_key         (wr_key),
    .wr_time        (wr_time)
  );

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    ntl_cell #(
      .IDX_W       (IDX_W),
      .CELL_INDEX  (i)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .in_flags      (chain_flags[i]),
      .in_key        (chain_key[i]),
      .in_found_idx  (chain_found_idx[i]),
      .in_best_time  (chain_best_time[i]),
      .in_best_idx   (chain_best_idx[i]),
      .out_flags     (chain_flags[i+1]),
      .out_key       (chain_key[i+1]),
      .out_found_idx (chain_found_idx[i+1]),
      .out_best_time (chain_best_time[i+1]),
      .out_best_idx  (chain_best_idx[i+1]),
      .wr_en         (wr_en),
      .wr_idx        (wr_idx),
      .wr_key        (wr_key),
      .wr_time       (wr_time)
    );
  end

endmodule
